// ===== sv/fsc_pkg.sv =====
package fsc_pkg;

	// Input range and conversion
	localparam int VALUE_W    = 14;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;
	localparam int CONV_STEPS = VALUE_W;

	// Display layout
	localparam int DIGITS    = 4;
	localparam int FRAME_W   = 16;
	localparam int RUN_BITS  = DIGITS * FRAME_W;
	localparam logic [7:0] BLANK_CODE = 8'hFF;
	localparam logic [1:0] SLOT_THOUSANDS = 2'd3;

	// Queue between front and back
	localparam int QDEPTH = 2;

	// Segment bytes of the four digits, index 0 is the units digit
	typedef logic [DIGITS-1:0][7:0] fsc_segs_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} fsc_qstat_t;

	// Front sequencer states
	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CONV,
		FR_PUSH
	} fr_state_t;

	// Map a decimal digit to its active-low segment byte
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] code;
		unique case (d)
			4'd0: code = 8'hC0;
			4'd1: code = 8'hF9;
			4'd2: code = 8'hA4;
			4'd3: code = 8'hB0;
			4'd4: code = 8'h99;
			4'd5: code = 8'h92;
			4'd6: code = 8'h82;
			4'd7: code = 8'hF8;
			4'd8: code = 8'h80;
			4'd9: code = 8'h90;
			default: code = BLANK_CODE;
		endcase
		return code;
	endfunction

endpackage

// ===== sv/four_digit_seven_segment_serializer.sv =====
// Drives a four-digit seven-segment display through a shift-register chain.
// Each accepted value (saturated to 9999) becomes 64 output items: four
// 16-bit frames, units digit first, each the active-low segment byte then a
// one-hot digit-select byte, MSB first. Leading zeros are blanked (0xFF).
// latch_strobe marks the last bit of each frame, last marks the 64th item.
// The serializer emits one bit per cycle while the queue holds a value and
// out_ready does not stall it. The front converts a value to decimal digits,
// overlapped with the serializer through a two-entry queue, so one value can
// wait in the queue and another in the front while a third is being shifted out.
module four_digit_seven_segment_serializer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [fsc_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         serial_data,
	output logic                         latch_strobe,
	output logic [1:0]                   digit_slot,
	output logic                         last
);
	import fsc_pkg::*;

	logic        q_push, q_pop;
	fsc_segs_t   push_segs, head_segs;
	fsc_qstat_t  qstat;

	// Accept and convert values
	fsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.push      (q_push),
		.push_segs (push_segs),
		.qstat     (qstat)
	);

	// Hold converted items
	fsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_segs (push_segs),
		.pop       (q_pop),
		.head_segs (head_segs),
		.qstat     (qstat)
	);

	// Shift out frames
	fsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_segs    (head_segs),
		.qstat        (qstat),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.serial_data  (serial_data),
		.latch_strobe (latch_strobe),
		.digit_slot   (digit_slot),
		.last         (last)
	);

	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("push into full queue");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !qstat.empty)
		else $error("pop from empty queue");

	// End of run closes the thousands frame
	a_last_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (latch_strobe && digit_slot == SLOT_THOUSANDS))
		else $error("last outside final frame bit");

	// A pop always leaves the last item of the run in the output register
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid && last))
		else $error("pop not aligned with last item");

endmodule

// ===== sv/fsc_front.sv =====
module fsc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fsc_pkg::VALUE_W-1:0]    value,
	output logic                           push,
	output fsc_pkg::fsc_segs_t             push_segs,
	input  fsc_pkg::fsc_qstat_t            qstat
);
	import fsc_pkg::*;

	fr_state_t              state_q, state_d;
	logic [VALUE_W-1:0]     bin_q;
	logic [4*DIGITS-1:0]    bcd_q;
	logic [3:0]             step_q;
	logic [4*DIGITS-1:0]    bcd_adj;
	logic                   accept;
	logic                   blank3, blank2, blank1;

	assign accept = in_valid && in_ready;

	// Add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	// Blank leading zeros from the thousands down, keep units
	assign blank3 = (bcd_q[15:12] == 4'd0);
	assign blank2 = blank3 && (bcd_q[11:8] == 4'd0);
	assign blank1 = blank2 && (bcd_q[7:4] == 4'd0);

	assign push_segs[3] = blank3 ? BLANK_CODE : seg_code(bcd_q[15:12]);
	assign push_segs[2] = blank2 ? BLANK_CODE : seg_code(bcd_q[11:8]);
	assign push_segs[1] = blank1 ? BLANK_CODE : seg_code(bcd_q[7:4]);
	assign push_segs[0] = seg_code(bcd_q[3:0]);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FR_CONV)
				step_q <= step_q + 4'd1;
			else
				step_q <= '0;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = FR_CONV;
			end
			FR_CONV: begin
				if (step_q == 4'(CONV_STEPS - 1))
					state_d = FR_PUSH;
			end
			FR_PUSH: begin
				push = !qstat.full;
				if (!qstat.full)
					state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	// Saturate on accept, then shift binary into BCD one bit a cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= (value > VALUE_MAX) ? VALUE_MAX : value;
			bcd_q <= '0;
		end else if (state_q == FR_CONV) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[4*DIGITS-2:0], bin_q[VALUE_W-1]};
		end
	end

endmodule

// ===== sv/fsc_queue.sv =====
module fsc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fsc_pkg::fsc_segs_t    push_segs,
	input  logic                  pop,
	output fsc_pkg::fsc_segs_t    head_segs,
	output fsc_pkg::fsc_qstat_t   qstat
);
	import fsc_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	fsc_segs_t          mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign qstat.full  = (count_q == CNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_segs   = mem_q[rd_ptr_q];

	// Store pushed item
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_segs;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/fsc_back.sv =====
module fsc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fsc_pkg::fsc_segs_t    head_segs,
	input  fsc_pkg::fsc_qstat_t   qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  serial_data,
	output logic                  latch_strobe,
	output logic [1:0]            digit_slot,
	output logic                  last
);
	import fsc_pkg::*;

	localparam int BIT_W = $clog2(RUN_BITS);

	logic [BIT_W-1:0]   bit_q;
	logic               out_valid_q;
	logic               data_q, strobe_q, last_q;
	logic [1:0]         slot_q;
	logic               advance, emit;
	logic [1:0]         slot;
	logic [3:0]         pos;
	logic [FRAME_W-1:0] frame;

	// Move the output register when empty or taken
	assign advance = !out_valid_q || out_ready;
	assign emit    = advance && !qstat.empty;
	assign pop     = emit && (bit_q == BIT_W'(RUN_BITS - 1));

	// Build the frame of the current digit from the queue head
	assign slot  = bit_q[BIT_W-1 -: 2];
	assign pos   = bit_q[3:0];
	assign frame = {head_segs[slot], 8'(8'd1 << slot)};

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			bit_q       <= '0;
		end else begin
			if (advance)
				out_valid_q <= !qstat.empty;
			if (emit)
				bit_q <= bit_q + 1'b1;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			data_q   <= frame[4'(FRAME_W - 1) - pos];
			strobe_q <= (pos == 4'(FRAME_W - 1));
			slot_q   <= slot;
			last_q   <= (bit_q == BIT_W'(RUN_BITS - 1));
		end
	end

	assign out_valid    = out_valid_q;
	assign serial_data  = data_q;
	assign latch_strobe = strobe_q;
	assign digit_slot   = slot_q;
	assign last         = last_q;

endmodule

// ===== tb/tb_four_digit_seven_segment_serializer.sv =====
module tb_four_digit_seven_segment_serializer;
	timeunit 1ns;
	timeprecision 1ps;

	import fsc_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 200;
	localparam int MAX_REPORTS = 100;

	// Active-low segment bytes of the decimal digits 0 to 9
	localparam logic [7:0] DIGIT_SEGS [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	// One shifted bit with its side fields
	typedef struct packed {
		logic       data;
		logic       strobe;
		logic [1:0] slot;
		logic       run_end;
	} shift_bit_t;

	// Predict the 64-bit frame run of each value and check shifted bits in order
	class frame_scoreboard;
		shift_bit_t pending_bits[$];
		int         errors = 0;
		int         reports = 0;

		function void note_value(logic [VALUE_W-1:0] v);
			int unsigned n;
			int unsigned dig[DIGITS];
			bit          blank[DIGITS];
			logic [7:0]  seg;
			logic [FRAME_W-1:0] frame;
			shift_bit_t  sb_bit;
			n = 32'(v);
			if (n > VALUE_MAX)
				n = 32'(VALUE_MAX);
			dig[3] = n / 1000;
			dig[2] = (n % 1000) / 100;
			dig[1] = (n % 100) / 10;
			dig[0] = n % 10;
			// blank leading zeros from the thousands down; units always shown
			blank[0] = 1'b0;
			blank[3] = (dig[3] == 0);
			blank[2] = blank[3] && (dig[2] == 0);
			blank[1] = blank[2] && (dig[1] == 0);
			for (int s = 0; s < DIGITS; s++) begin
				seg = blank[s] ? BLANK_CODE : DIGIT_SEGS[dig[s]];
				frame = {seg, 8'(1 << s)};
				for (int b = 0; b < FRAME_W; b++) begin
					sb_bit.data    = frame[FRAME_W-1-b];
					sb_bit.strobe  = (b == FRAME_W-1);
					sb_bit.slot    = 2'(s);
					sb_bit.run_end = (s == DIGITS-1) && (b == FRAME_W-1);
					pending_bits.push_back(sb_bit);
				end
			end
		endfunction

		function void report(string what, logic [1:0] exp_v, logic [1:0] got_v);
			errors++;
			if (reports < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
			reports++;
		endfunction

		function void check_bit(shift_bit_t got);
			shift_bit_t exp_b;
			if (pending_bits.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS)
					$display("%0t: unexpected output item, expected none, actual %p",
						$time, got);
				reports++;
				return;
			end
			exp_b = pending_bits.pop_front();
			if (got.data !== exp_b.data)
				report("serial_data", 2'(exp_b.data), 2'(got.data));
			if (got.strobe !== exp_b.strobe)
				report("latch_strobe", 2'(exp_b.strobe), 2'(got.strobe));
			if (got.slot !== exp_b.slot)
				report("digit_slot", exp_b.slot, got.slot);
			if (got.run_end !== exp_b.run_end)
				report("last", 2'(exp_b.run_end), 2'(got.run_end));
		endfunction

		function int pending();
			return pending_bits.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               serial_data;
	logic               latch_strobe;
	logic [1:0]         digit_slot;
	logic               last;

	frame_scoreboard scb = new();
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int idle_cycles = 0;

	four_digit_seven_segment_serializer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.serial_data  (serial_data),
		.latch_strobe (latch_strobe),
		.digit_slot   (digit_slot),
		.last         (last)
	);

	always #6 clk = ~clk;

	// Pick an idle length: mostly none or short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Pick a value spread over digit counts, inner zeros and above range
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		int unsigned v;
		r = $urandom_range(0, 99);
		if (r < 10)
			return VALUE_W'($urandom_range(0, 9));
		if (r < 25)
			return VALUE_W'($urandom_range(10, 99));
		if (r < 45)
			return VALUE_W'($urandom_range(100, 999));
		if (r < 75)
			return VALUE_W'($urandom_range(1000, 9999));
		if (r < 87)
			return VALUE_W'($urandom_range(10000, 16383));
		v = 0;
		for (int k = 0; k < DIGITS; k++)
			v = v * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 9));
		return VALUE_W'(v);
	endfunction

	// Offer one item after an optional gap and hold it until accepted
	task automatic send_value(logic [VALUE_W-1:0] v);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Drop valid and hold off until every expected bit has come out
	task automatic drain_outputs();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (scb.pending() != 0);
	endtask

	// Note accepted input items and check accepted output items
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			scb.note_value(value);
		if (arst_n && out_valid && out_ready)
			scb.check_bit('{serial_data, latch_strobe, digit_slot, last});
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Toggle output ready: bursts of acceptance and random stalls
	initial begin
		int run;
		int stall;
		forever begin
			if (rx_steady) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 8);
				out_ready <= 1'b1;
				repeat (run) @(posedge clk);
				stall = idle_len();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] directed[$];
		directed = '{
			14'd0, 14'd1, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000,
			14'd9999, 14'd10000, 14'd16383, 14'd1001, 14'd1010, 14'd1100,
			14'd9090, 14'd5000, 14'd305, 14'd40, 14'd8888, 14'd1234, 14'd7,
			14'd9998, 14'h2AAA, 14'h1555
		};

		// hold reset, then release it
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed values: extremes, blanking, inner zeros, saturation
		foreach (directed[i])
			send_value(directed[i]);
		drain_outputs();

		// random values, with steady stretches and one more full drain
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			tx_steady = (i >= 60 && i < 100);
			rx_steady = (i >= 60 && i < 110);
			if (i == 130)
				drain_outputs();
			send_value(pick_value());
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		// wait for the last bits, then a quiet tail
		drain_outputs();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (scb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
